### sv/lcd_mode_line_timer_top_assert.svh
// ----------------------------------------------------------------------------
// LCD mode/line timer assertion macros
// Shared concurrent assertion forms, clocked on clk_i, gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef LCD_MODE_LINE_TIMER_TOP_ASSERT_SVH
`define LCD_MODE_LINE_TIMER_TOP_ASSERT_SVH

// same-cycle implication
`define LMLT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LMLT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/lmlt_pkg.sv
// ----------------------------------------------------------------------------
// LCD mode/line timer package
// Mode codes, dot timing constants, register map and shared structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lmlt_pkg;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } mode_e;

  localparam int unsigned DotW   = 10;
  localparam int unsigned LineW  = 8;
  localparam int unsigned CycW   = 8;
  localparam int unsigned IenW   = 4;
  localparam int unsigned PaddrW = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [DotW-1:0] DOTS_OAM      = 10'd82;
  localparam logic [DotW-1:0] DOTS_XFER     = 10'd172;
  localparam logic [DotW-1:0] DOTS_HBLANK   = 10'd204;
  localparam logic [DotW-1:0] DOTS_VBL_LINE = 10'd456;
  localparam logic [DotW-1:0] DOT_MAX       = 10'd1023;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_DISP_EN  = 2'd0;
  localparam logic [1:0] REG_STAT_IEN = 2'd1;
  localparam logic [1:0] REG_LINE_CMP = 2'd2;

  // stat_irq_enables bit positions
  localparam int unsigned IEN_HBLANK = 0;
  localparam int unsigned IEN_VBLANK = 1;
  localparam int unsigned IEN_OAM    = 2;
  localparam int unsigned IEN_LYC    = 3;

  typedef struct packed {
    logic             en;
    logic [IenW-1:0]  stat_ien;
    logic [LineW-1:0] line_cmp;
  } cfg_t;

  typedef struct packed {
    logic [DotW-1:0]  dot;
    logic [LineW-1:0] line;
    mode_e            mode;
  } timing_t;

  typedef struct packed {
    logic [LineW-1:0] line;
    mode_e            mode;
    logic             coincidence;
    logic             stat_irq;
    logic             vblank_irq;
    logic             render_line;
  } result_t;

endpackage

`default_nettype wire

### sv/lmlt_step.sv
// ----------------------------------------------------------------------------
// LCD mode/line timer step
// Next dot/line/mode from the current timing state and one cycle count.
// ----------------------------------------------------------------------------
`default_nettype none

module lmlt_step #(
  parameter int unsigned VISIBLE_LINES = 144,
  parameter int unsigned LAST_LINE     = 153
) (
  input  lmlt_pkg::timing_t              cur_i,
  input  lmlt_pkg::cfg_t                 cfg_i,
  input  logic [lmlt_pkg::CycW-1:0]      cycles_i,
  output lmlt_pkg::timing_t              nxt_o,
  output lmlt_pkg::result_t              res_o
);
  import lmlt_pkg::*;

  localparam logic [LineW:0] VisLine  = (LineW+1)'(VISIBLE_LINES);
  localparam logic [LineW:0] LastLine = (LineW+1)'(LAST_LINE);

  logic [DotW:0]   sum;
  logic [DotW-1:0] d;
  logic [LineW:0]  nl;
  logic            moved;
  logic            stat;
  logic            vbl;
  logic            render;

  always_comb begin
    sum    = {1'b0, cur_i.dot} + {{(DotW+1-CycW){1'b0}}, cycles_i};
    d      = sum[DotW] ? DOT_MAX : sum[DotW-1:0];
    nl     = {1'b0, cur_i.line} + {{LineW{1'b0}}, 1'b1};
    nxt_o  = cur_i;
    moved  = 1'b0;
    stat   = 1'b0;
    vbl    = 1'b0;
    render = 1'b0;
    if (!cfg_i.en) begin
      nxt_o.dot  = '0;
      nxt_o.line = '0;
      nxt_o.mode = MODE_OAM;
    end else begin
      nxt_o.dot = d;
      unique case (cur_i.mode)
        MODE_OAM: begin
          if (d >= DOTS_OAM) begin
            nxt_o.dot  = d - DOTS_OAM;
            nxt_o.mode = MODE_XFER;
          end
        end
        MODE_XFER: begin
          if (d >= DOTS_XFER) begin
            nxt_o.dot  = d - DOTS_XFER;
            nxt_o.mode = MODE_HBLANK;
            stat       = cfg_i.stat_ien[IEN_HBLANK];
            render     = 1'b1;
          end
        end
        MODE_HBLANK: begin
          if (d >= DOTS_HBLANK) begin
            nxt_o.dot  = d - DOTS_HBLANK;
            nxt_o.line = nl[LineW-1:0];
            moved      = 1'b1;
            if (nl == VisLine) begin
              nxt_o.mode = MODE_VBLANK;
              vbl        = 1'b1;
              stat       = cfg_i.stat_ien[IEN_VBLANK];
            end else begin
              nxt_o.mode = MODE_OAM;
              stat       = cfg_i.stat_ien[IEN_OAM];
            end
          end
        end
        MODE_VBLANK: begin
          if (d >= DOTS_VBL_LINE) begin
            moved = 1'b1;
            if (nl > LastLine) begin
              nxt_o.dot  = '0;
              nxt_o.line = '0;
              nxt_o.mode = MODE_OAM;
              stat       = cfg_i.stat_ien[IEN_OAM];
            end else begin
              nxt_o.dot  = d - DOTS_VBL_LINE;
              nxt_o.line = nl[LineW-1:0];
            end
          end
        end
      endcase
      if (moved && (nxt_o.line == cfg_i.line_cmp) && cfg_i.stat_ien[IEN_LYC]) begin
        stat = 1'b1;
      end
    end
    res_o.line        = nxt_o.line;
    res_o.mode        = nxt_o.mode;
    res_o.coincidence = (nxt_o.line == cfg_i.line_cmp);
    res_o.stat_irq    = stat;
    res_o.vblank_irq  = vbl;
    res_o.render_line = render;
  end

endmodule

`default_nettype wire

### sv/lcd_mode_line_timer_top.sv
// ----------------------------------------------------------------------------
// LCD mode/line timer
// Dot counter, line counter and display mode of an LCD controller, with
// status/vblank interrupt pulses and a render request per line.
// ----------------------------------------------------------------------------
// Each request carries an elapsed cycle count and yields one result. The
// block sustains one request per clock while out_ready_i is high. A request
// is captured in the input register, then one add/saturate/compare/subtract
// step moves it into the result register, which also updates the timing
// state. While out_ready_i is low the result register holds, one more request
// waits in the input register, and in_ready_o drops until the result is taken.
// Registers: 0x0 display enable, 0x4 STAT interrupt enables, 0x8 line compare.
`default_nettype none

`include "lcd_mode_line_timer_top_assert.svh"

module lcd_mode_line_timer_top #(
  parameter int unsigned VISIBLE_LINES = 144,
  parameter int unsigned LAST_LINE     = 153
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lmlt_pkg::PaddrW-1:0]     paddr,
  input  logic [lmlt_pkg::DataW-1:0]      pwdata,
  output logic [lmlt_pkg::DataW-1:0]      prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lmlt_pkg::CycW-1:0]       cycles_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [lmlt_pkg::LineW-1:0]      line_o,
  output logic [1:0]                      mode_o,
  output logic                            coincidence_o,
  output logic                            stat_irq_o,
  output logic                            vblank_irq_o,
  output logic                            render_line_o
);
  import lmlt_pkg::*;

  cfg_t             cfg_q;
  logic             cfg_wr;
  logic [1:0]       reg_idx;

  logic             in_valid_q;
  logic [CycW-1:0]  cycles_q;
  logic             out_valid_q;
  result_t          res_q;
  timing_t          tim_q;
  timing_t          tim_d;
  result_t          res_d;
  logic             advance;

  // config port
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DISP_EN:  cfg_q.en       <= pwdata[0];
        REG_STAT_IEN: cfg_q.stat_ien <= pwdata[IenW-1:0];
        REG_LINE_CMP: cfg_q.line_cmp <= pwdata[LineW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DISP_EN:  prdata = {{(DataW-1){1'b0}}, cfg_q.en};
      REG_STAT_IEN: prdata = {{(DataW-IenW){1'b0}}, cfg_q.stat_ien};
      REG_LINE_CMP: prdata = {{(DataW-LineW){1'b0}}, cfg_q.line_cmp};
      default:      prdata = '0;
    endcase
  end

  // input register -> step -> result register
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cycles_q <= cycles_i;
    end
  end

  lmlt_step #(
    .VISIBLE_LINES (VISIBLE_LINES),
    .LAST_LINE     (LAST_LINE)
  ) u_step (
    .cur_i    (tim_q),
    .cfg_i    (cfg_q),
    .cycles_i (cycles_q),
    .nxt_o    (tim_d),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tim_q.dot   <= '0;
      tim_q.line  <= '0;
      tim_q.mode  <= MODE_OAM;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      tim_q       <= tim_d;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign line_o        = res_q.line;
  assign mode_o        = res_q.mode;
  assign coincidence_o = res_q.coincidence;
  assign stat_irq_o    = res_q.stat_irq;
  assign vblank_irq_o  = res_q.vblank_irq;
  assign render_line_o = res_q.render_line;

  `LMLT_ASSERT_NEXT(a_disabled_holds, advance && !cfg_q.en,
    tim_q.dot == '0 && tim_q.line == '0 && tim_q.mode == MODE_OAM,
    "disabled display did not hold timing at line 0 OAM")
  `LMLT_ASSERT_NOW(a_vblank_entry, out_valid_o && vblank_irq_o,
    mode_o == MODE_VBLANK && line_o == LineW'(VISIBLE_LINES),
    "vblank pulse outside vblank entry")
  `LMLT_ASSERT_NOW(a_render_hblank, out_valid_o && render_line_o, mode_o == MODE_HBLANK,
    "render request outside hblank entry")
  `LMLT_ASSERT_NOW(a_stat_enabled, out_valid_o && stat_irq_o, cfg_q.stat_ien != '0,
    "status pulse with all enables clear")

endmodule

`default_nettype wire
